// ----- hdl/npcs_pkg.sv -----
// Shared constants and types for the nearest palette color search block.
package npcs_pkg;

    // Palette geometry.
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);

    // Field widths.
    localparam int CHAN_W  = 8;
    localparam int INDEX_W = 8;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int DIST_W  = 18;
    localparam int COLOR_W = 3 * CHAN_W;

    // Request operation codes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Search sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_LOAD
    } state_t;

endpackage

// ----- hdl/nearest_palette_color_search.sv -----
// Nearest palette color search: palette memory, scan pipeline and result register.
//
//  Channel   Handshake             Payload
//  -------   -------------------   ------------------------------------------
//  request   req_valid/req_stall   operation, entry_index, red, green, blue
//  response  rsp_valid/rsp_stall   closest_index, min_distance
//
// A palette write leaves the sequencer idle, so the request side stays open. A search
// holds the request side from its acceptance until its result load: one memory read
// per entry over the single read port, then the square stage, the sum and compare
// stage and the result load. Reset clears per-entry valid bits, so unwritten entries
// read as black at once. A stalled response holds; a finished search waits in its best
// registers until the response register is free, and new requests are held off
// meanwhile.
module nearest_palette_color_search (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         operation,
    input  logic [npcs_pkg::INDEX_W-1:0] entry_index,
    input  logic [npcs_pkg::CHAN_W-1:0]  red,
    input  logic [npcs_pkg::CHAN_W-1:0]  green,
    input  logic [npcs_pkg::CHAN_W-1:0]  blue,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [npcs_pkg::INDEX_W-1:0] closest_index,
    output logic [npcs_pkg::DIST_W-1:0]  min_distance
);
    import npcs_pkg::*;

    // Palette memory and its valid bits.
    logic [COLOR_W-1:0]         pal_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] pal_vld_reg;

    state_t state_reg, state_next;

    // Query color.
    logic [CHAN_W-1:0] q_red_reg, q_green_reg, q_blue_reg;

    // Scan address and read stage.
    logic [PAL_IDX_W-1:0] scan_addr_reg;
    logic [COLOR_W-1:0]   rd_data_reg;
    logic                 rd_ent_vld_reg;
    logic                 s1_vld_reg, s1_last_reg;
    logic [PAL_IDX_W-1:0] s1_idx_reg;

    // Square stage.
    logic                 s2_vld_reg, s2_last_reg;
    logic [PAL_IDX_W-1:0] s2_idx_reg;
    logic [SQ_W-1:0]      sq_r_reg, sq_g_reg, sq_b_reg;

    // Running best.
    logic [PAL_IDX_W-1:0] best_idx_reg;
    logic [DIST_W-1:0]    best_dist_reg;

    // Response register.
    logic                 rsp_valid_reg;
    logic [INDEX_W-1:0]   rsp_idx_reg;
    logic [DIST_W-1:0]    rsp_dist_reg;

    logic                 req_take, wr_en, search_start;
    logic                 scan_issue, load_out, rsp_free, scan_last;
    logic [PAL_IDX_W-1:0] wr_addr;
    logic [CHAN_W-1:0]    e_red, e_green, e_blue;
    logic [CHAN_W-1:0]    d_red, d_green, d_blue;
    logic [DIST_W-1:0]    sum_dist;

    // Request decode.
    assign req_take     = req_valid && !req_stall;
    assign wr_addr      = PAL_IDX_W'(entry_index);
    assign wr_en        = req_take && (operation == OP_WRITE)
                          && (32'(entry_index) < PALETTE_ENTRIES);
    assign search_start = req_take && (operation == OP_SEARCH);
    assign scan_last    = (32'(scan_addr_reg) == PALETTE_ENTRIES - 1);
    assign rsp_free     = !rsp_valid_reg || !rsp_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (search_start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s2_vld_reg && s2_last_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        req_stall  = 1'b1;
        scan_issue = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:  req_stall  = 1'b0;
            ST_SCAN:  scan_issue = 1'b1;
            ST_DRAIN: scan_issue = 1'b0;
            ST_LOAD:  load_out   = rsp_free;
            default:  req_stall  = 1'b1;
        endcase
    end

    // Sequencer state and scan control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_addr_reg <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            pal_vld_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_vld_reg <= scan_issue;
            s2_vld_reg <= s1_vld_reg;
            if (search_start)
            begin
                scan_addr_reg <= '0;
            end
            else if (scan_issue)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (wr_en)
            begin
                pal_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pal_mem[wr_addr] <= {red, green, blue};
        end
        rd_data_reg    <= pal_mem[scan_addr_reg];
        rd_ent_vld_reg <= pal_vld_reg[scan_addr_reg];
    end

    // Query capture and index tags along the pipeline.
    always_ff @(posedge clk)
    begin
        if (search_start)
        begin
            q_red_reg   <= red;
            q_green_reg <= green;
            q_blue_reg  <= blue;
        end
        s1_idx_reg  <= scan_addr_reg;
        s1_last_reg <= scan_last;
        s2_idx_reg  <= s1_idx_reg;
        s2_last_reg <= s1_last_reg;
    end

    // Entries never written read as black.
    assign e_red   = rd_ent_vld_reg ? rd_data_reg[3*CHAN_W-1:2*CHAN_W] : '0;
    assign e_green = rd_ent_vld_reg ? rd_data_reg[2*CHAN_W-1:CHAN_W]   : '0;
    assign e_blue  = rd_ent_vld_reg ? rd_data_reg[CHAN_W-1:0]          : '0;

    // Absolute channel differences.
    assign d_red   = (q_red_reg > e_red)     ? q_red_reg - e_red     : e_red - q_red_reg;
    assign d_green = (q_green_reg > e_green) ? q_green_reg - e_green : e_green - q_green_reg;
    assign d_blue  = (q_blue_reg > e_blue)   ? q_blue_reg - e_blue   : e_blue - q_blue_reg;

    // Square stage.
    always_ff @(posedge clk)
    begin
        sq_r_reg <= SQ_W'(d_red) * SQ_W'(d_red);
        sq_g_reg <= SQ_W'(d_green) * SQ_W'(d_green);
        sq_b_reg <= SQ_W'(d_blue) * SQ_W'(d_blue);
    end

    assign sum_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    // Running minimum; the first entry seeds it and ties keep the lower index.
    always_ff @(posedge clk)
    begin
        if (s2_vld_reg && ((s2_idx_reg == '0) || (sum_dist < best_dist_reg)))
        begin
            best_dist_reg <= sum_dist;
            best_idx_reg  <= s2_idx_reg;
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rsp_idx_reg  <= INDEX_W'(best_idx_reg);
            rsp_dist_reg <= best_dist_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign closest_index = rsp_idx_reg;
    assign min_distance  = rsp_dist_reg;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the nearest palette color search block.
`timescale 1ns / 1ps

module tb_top;
    import npcs_pkg::*;

    localparam int RANDOM_REQUESTS = 1280;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 300;

    // Shadow palette and queue of pending search answers.
    class palette_scoreboard;
        typedef struct packed {
            logic [INDEX_W-1:0] index;
            logic [DIST_W-1:0]  distance;
        } match_t;

        logic [COLOR_W-1:0] palette [PALETTE_ENTRIES];
        match_t             answers_q [$];
        int                 errors;

        function new();
            foreach (palette[i]) palette[i] = '0;
            errors = 0;
        endfunction

        // Scan the whole palette; the first entry seeds the running minimum.
        function match_t nearest_entry(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                       logic [CHAN_W-1:0] b);
            match_t best;
            int     dr;
            int     dg;
            int     db;
            int     d;
            int     best_d;
            int     best_i;
            best_d = 0;
            best_i = 0;
            for (int i = 0; i < PALETTE_ENTRIES; i++)
            begin
                dr = int'(r) - int'(palette[i][3*CHAN_W-1:2*CHAN_W]);
                dg = int'(g) - int'(palette[i][2*CHAN_W-1:CHAN_W]);
                db = int'(b) - int'(palette[i][CHAN_W-1:0]);
                d  = dr * dr + dg * dg + db * db;
                if (i == 0 || d < best_d)
                begin
                    best_d = d;
                    best_i = i;
                end
            end
            best.index    = best_i[INDEX_W-1:0];
            best.distance = best_d[DIST_W-1:0];
            return best;
        endfunction

        // An accepted request either updates the palette or expects one answer.
        function void note_request(logic op, logic [INDEX_W-1:0] idx,
                                   logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                   logic [CHAN_W-1:0] b);
            if (op == OP_WRITE)
            begin
                if (int'(idx) < PALETTE_ENTRIES)
                    palette[idx] = {r, g, b};
            end
            else
            begin
                answers_q.push_back(nearest_entry(r, g, b));
            end
        endfunction

        function void check_result(logic [INDEX_W-1:0] idx, logic [DIST_W-1:0] distance);
            match_t want;
            if (answers_q.size() == 0)
            begin
                $error("unexpected result: closest_index %0d min_distance %0d", idx, distance);
                errors++;
                return;
            end
            want = answers_q.pop_front();
            if (idx !== want.index)
            begin
                $error("closest_index: expected %0d, actual %0d", want.index, idx);
                errors++;
            end
            if (distance !== want.distance)
            begin
                $error("min_distance: expected %0d, actual %0d", want.distance, distance);
                errors++;
            end
        endfunction

        function int pending();
            return answers_q.size();
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                req_valid     = 1'b0;
    logic                req_stall;
    logic                operation     = OP_WRITE;
    logic [INDEX_W-1:0]  entry_index   = '0;
    logic [CHAN_W-1:0]   red           = '0;
    logic [CHAN_W-1:0]   green         = '0;
    logic [CHAN_W-1:0]   blue          = '0;
    logic                rsp_valid;
    logic                rsp_stall     = 1'b0;
    logic [INDEX_W-1:0]  closest_index;
    logic [DIST_W-1:0]   min_distance;

    logic                quiet         = 1'b0;
    int                  idle_cycles   = 0;

    palette_scoreboard   sb = new();

    nearest_palette_color_search uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .operation     (operation),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .closest_index (closest_index),
        .min_distance  (min_distance)
    );

    always #4 clk = ~clk;

    // Response side stalls at random, except in the quiet stretch.
    always @(posedge clk)
    begin
        rsp_stall <= !quiet && ($urandom_range(99) < 29);
    end

    // Monitor both channels and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(operation, entry_index, red, green, blue);
            if (rsp_valid && !rsp_stall)
                sb.check_result(closest_index, min_distance);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Present one request, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx,
                                input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                input logic [CHAN_W-1:0] b);
        while (!quiet && $urandom_range(99) < 29)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        operation   <= op;
        entry_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        do @(posedge clk); while (req_stall);
    endtask

    // Hold off new requests until every pending search has answered.
    task automatic drain_searches();
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Channel value that hits the extremes now and then.
    function automatic logic [CHAN_W-1:0] random_channel();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? {CHAN_W{1'b1}} : {CHAN_W{1'b0}};
        return CHAN_W'($urandom_range((1 << CHAN_W) - 1));
    endfunction

    // Move a channel by a few steps, clamped to its range.
    function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > (1 << CHAN_W) - 1)
            v = (1 << CHAN_W) - 1;
        return v[CHAN_W-1:0];
    endfunction

    initial
    begin
        int                 kind;
        int                 pick;
        logic [COLOR_W-1:0] color;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Black palette after reset: every entry ties, so index zero wins.
        send_request(OP_SEARCH, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(OP_SEARCH, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

        // White at the top entry, then a tie with the bottom entry.
        send_request(OP_WRITE,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_SEARCH, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_SEARCH, 8'hFF, 8'd200, 8'd200, 8'd200);
        send_request(OP_WRITE,  8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_SEARCH, 8'h80, 8'hFF, 8'hFF, 8'hFF);

        // Primaries at scattered entries; black now first found at entry one.
        send_request(OP_WRITE,  8'd128, 8'hFF, 8'h00, 8'h00);
        send_request(OP_WRITE,  8'd64,  8'h00, 8'hFF, 8'h00);
        send_request(OP_WRITE,  8'd32,  8'h00, 8'h00, 8'hFF);
        send_request(OP_SEARCH, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_request(OP_SEARCH, 8'h00, 8'h00, 8'hFF, 8'h00);
        send_request(OP_SEARCH, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_request(OP_SEARCH, 8'h00, 8'h00, 8'h00, 8'h00);

        // Alternating bit patterns in every field.
        send_request(OP_WRITE,  8'hAA, 8'hAA, 8'h55, 8'hAA);
        send_request(OP_WRITE,  8'h55, 8'h55, 8'hAA, 8'h55);
        send_request(OP_SEARCH, 8'h55, 8'hAA, 8'h55, 8'hAA);
        send_request(OP_SEARCH, 8'hAA, 8'h55, 8'hAA, 8'h55);

        // Two entries equally close to the query: the lower index is kept.
        send_request(OP_WRITE,  8'd10, 8'd100, 8'd100, 8'd100);
        send_request(OP_WRITE,  8'd11, 8'd102, 8'd100, 8'd100);
        send_request(OP_SEARCH, 8'h00, 8'd101, 8'd100, 8'd100);

        drain_searches();

        // Random traffic: writes build up the palette, searches probe it.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            quiet <= (n >= 500 && n < 700);
            if (n == 900)
                drain_searches();
            kind = $urandom_range(99);
            pick = $urandom_range(PALETTE_ENTRIES - 1);
            color = sb.palette[pick];
            if (kind < 45)
            begin
                send_request(OP_WRITE, INDEX_W'($urandom_range(255)), random_channel(),
                             random_channel(), random_channel());
            end
            else if (kind < 55)
            begin
                // Copy of an existing color, often exact, to set up ties.
                if ($urandom_range(1))
                    color = {nudge(color[23:16]), nudge(color[15:8]), nudge(color[7:0])};
                send_request(OP_WRITE, INDEX_W'($urandom_range(255)),
                             color[23:16], color[15:8], color[7:0]);
            end
            else if (kind < 80)
            begin
                // Query at or close to a palette color.
                if ($urandom_range(2) != 0)
                    color = {nudge(color[23:16]), nudge(color[15:8]), nudge(color[7:0])};
                send_request(OP_SEARCH, INDEX_W'($urandom_range(255)),
                             color[23:16], color[15:8], color[7:0]);
            end
            else
            begin
                send_request(OP_SEARCH, INDEX_W'($urandom_range(255)), random_channel(),
                             random_channel(), random_channel());
            end
        end

        drain_searches();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            if (sb.pending() != 0)
                $error("%0d search results never arrived", sb.pending());
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/npcs_pkg.sv
hdl/nearest_palette_color_search.sv
tb/tb_top.sv
